/* rtl/aspc_pkg.sv */
// Shared types and constants for the adaptive signal phase controller.
`default_nettype none

package aspc_pkg;

	localparam int QUEUE_BITS   = 8;
	localparam int NUM_APPROACH = 4;
	localparam int DIR_W        = 2;
	localparam int ARRIVE_W     = 2;
	localparam int ALLOW_W      = 2;
	localparam int GREEN_W      = 6;
	localparam int QOUT_W       = 8;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 3;

	// width of min_green + queue before the clamp
	localparam int GLEN_W = ((QUEUE_BITS > GREEN_W) ? QUEUE_BITS : GREEN_W) + 1;

	localparam logic [GREEN_W-1:0] MIN_GREEN_RESET = GREEN_W'(5);
	localparam logic [GREEN_W-1:0] MAX_GREEN_RESET = GREEN_W'(15);

	typedef logic [QUEUE_BITS-1:0] queue_t;
	typedef logic [GREEN_W-1:0]    green_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_NORTH = 2'd0,
		DIR_EAST  = 2'd1,
		DIR_SOUTH = 2'd2,
		DIR_WEST  = 2'd3
	} dir_t;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_MIN_GREEN = 1'b0,
		REG_MAX_GREEN = 1'b1
	} reg_idx_t;

endpackage

`default_nettype wire

/* rtl/aspc_if.sv */
// Valid/ready channel interfaces for tick requests and phase results.
`default_nettype none

interface aspc_tick_if;
	logic                               valid;
	logic                               ready;
	logic [aspc_pkg::ARRIVE_W-1:0]      arrive_north;
	logic [aspc_pkg::ARRIVE_W-1:0]      arrive_east;
	logic [aspc_pkg::ARRIVE_W-1:0]      arrive_south;
	logic [aspc_pkg::ARRIVE_W-1:0]      arrive_west;
	logic [aspc_pkg::ALLOW_W-1:0]       depart_allow;

	modport source (
		output valid, arrive_north, arrive_east, arrive_south, arrive_west, depart_allow,
		input  ready
	);
	modport sink (
		input  valid, arrive_north, arrive_east, arrive_south, arrive_west, depart_allow,
		output ready
	);
endinterface

interface aspc_result_if;
	logic                               valid;
	logic                               ready;
	logic                               phase_start;
	logic [aspc_pkg::DIR_W-1:0]         green_dir;
	logic [aspc_pkg::GREEN_W-1:0]       green_len;
	logic [aspc_pkg::GREEN_W-1:0]       ticks_left;
	logic [aspc_pkg::ALLOW_W-1:0]       departed;
	logic [aspc_pkg::QOUT_W-1:0]        queue_north;
	logic [aspc_pkg::QOUT_W-1:0]        queue_east;
	logic [aspc_pkg::QOUT_W-1:0]        queue_south;
	logic [aspc_pkg::QOUT_W-1:0]        queue_west;

	modport source (
		output valid, phase_start, green_dir, green_len, ticks_left, departed,
		       queue_north, queue_east, queue_south, queue_west,
		input  ready
	);
	modport sink (
		input  valid, phase_start, green_dir, green_len, ticks_left, departed,
		       queue_north, queue_east, queue_south, queue_west,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/adaptive_signal_phase_controller_core.sv */
// Adaptive signal phase controller: queue tracking, green selection and countdown.
//
// Usage:
//  - tick (sink): one request per intersection tick, carrying the arrivals on
//    the four approaches and the departure allowance for the green queue.
//  - result (source): one result per tick with the phase decision, the green
//    direction, phase length, ticks left, departures and all four queue lengths.
//  - APB port: min_green at 0x0, max_green at 0x4. Write only while idle.
//  - Results are registered: a request's result shows in the cycle after it
//    is taken. Throughput is one request per cycle unless the result stalls;
//    the queue and phase state update in the same cycle the request is taken,
//    so the next tick reads it at once. The result register is the only stage.
//  - tick.ready is low only while a result is held and result.ready is low;
//    the result then holds until taken, and no new request is accepted.
//  - Reset clears all queues and the phase counter, so the first tick opens
//    a green phase; min_green and max_green reset to 5 and 15.
`default_nettype none

module adaptive_signal_phase_controller_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	aspc_tick_if.sink                             tick,
	aspc_result_if.source                         result,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [aspc_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [aspc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [aspc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready
);

	localparam int NA = aspc_pkg::NUM_APPROACH;
	localparam int QB = aspc_pkg::QUEUE_BITS;
	localparam int GW = aspc_pkg::GREEN_W;
	localparam int LW = aspc_pkg::GLEN_W;

	// configuration
	aspc_pkg::green_t min_green_q, max_green_q;
	aspc_pkg::reg_idx_t reg_sel;
	logic cfg_wr;

	// state
	aspc_pkg::queue_t queue_q [NA];
	aspc_pkg::dir_t   cur_green_q;
	aspc_pkg::green_t phase_len_q;
	aspc_pkg::green_t remaining_q;

	// result register
	logic                              res_valid_s1;
	logic                              phase_start_s1;
	aspc_pkg::dir_t                    green_dir_s1;
	aspc_pkg::green_t                  green_len_s1;
	aspc_pkg::green_t                  ticks_left_s1;
	logic [aspc_pkg::ALLOW_W-1:0]      departed_s1;
	aspc_pkg::queue_t                  queue_s1 [NA];

	// next-state logic
	logic [aspc_pkg::ARRIVE_W-1:0] arrive [NA];
	logic [QB:0]                   sum [NA];
	aspc_pkg::queue_t              q_arr [NA];
	aspc_pkg::queue_t              q_next [NA];
	aspc_pkg::dir_t                best;
	logic [LW-1:0]                 base_len;
	aspc_pkg::green_t              new_len;
	aspc_pkg::queue_t              q_green;
	logic [aspc_pkg::ALLOW_W-1:0]  departed;
	logic                          deciding;
	logic                          in_fire;
	aspc_pkg::dir_t                dir_next;
	aspc_pkg::green_t              len_next;
	aspc_pkg::green_t              rem_next;

	// ---------------- APB ----------------
	assign pready  = 1'b1;
	assign reg_sel = aspc_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		case (reg_sel)
			aspc_pkg::REG_MIN_GREEN: prdata = aspc_pkg::APB_DATA_W'(min_green_q);
			aspc_pkg::REG_MAX_GREEN: prdata = aspc_pkg::APB_DATA_W'(max_green_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_green_q <= aspc_pkg::MIN_GREEN_RESET;
			max_green_q <= aspc_pkg::MAX_GREEN_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				aspc_pkg::REG_MIN_GREEN: min_green_q <= pwdata[GW-1:0];
				aspc_pkg::REG_MAX_GREEN: max_green_q <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	assign tick.ready = !res_valid_s1 || result.ready;
	assign in_fire    = tick.valid && tick.ready;

	// ---------------- tick update ----------------
	assign arrive[0] = tick.arrive_north;
	assign arrive[1] = tick.arrive_east;
	assign arrive[2] = tick.arrive_south;
	assign arrive[3] = tick.arrive_west;

	always_comb begin
		for (int d = 0; d < NA; d++) begin
			sum[d]   = {1'b0, queue_q[d]} + (QB+1)'(arrive[d]);
			q_arr[d] = sum[d][QB] ? {QB{1'b1}} : sum[d][QB-1:0];
		end
	end

	// longest queue, lowest index wins ties
	always_comb begin
		best = aspc_pkg::DIR_NORTH;
		for (int d = 1; d < NA; d++) begin
			if (q_arr[d] > q_arr[best])
				best = aspc_pkg::dir_t'(d);
		end
	end

	// base never falls below min_green, so only the upper clamp matters
	assign base_len = LW'(min_green_q) + LW'(q_arr[best]);
	assign new_len  = (base_len > LW'(max_green_q)) ? max_green_q : base_len[GW-1:0];

	assign deciding = (remaining_q == '0);
	assign q_green  = q_arr[cur_green_q];
	assign departed = (q_green < QB'(tick.depart_allow)) ? q_green[aspc_pkg::ALLOW_W-1:0]
	                                                     : tick.depart_allow;

	always_comb begin
		for (int d = 0; d < NA; d++) begin
			if (!deciding && (aspc_pkg::dir_t'(d) == cur_green_q))
				q_next[d] = q_arr[d] - QB'(departed);
			else
				q_next[d] = q_arr[d];
		end
		if (deciding) begin
			dir_next = best;
			len_next = new_len;
			rem_next = new_len;
		end else begin
			dir_next = cur_green_q;
			len_next = phase_len_q;
			rem_next = remaining_q - GW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NA; d++)
				queue_q[d] <= '0;
			cur_green_q <= aspc_pkg::DIR_NORTH;
			phase_len_q <= '0;
			remaining_q <= '0;
		end else if (in_fire) begin
			for (int d = 0; d < NA; d++)
				queue_q[d] <= q_next[d];
			cur_green_q <= dir_next;
			phase_len_q <= len_next;
			remaining_q <= rem_next;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			res_valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			phase_start_s1 <= deciding;
			green_dir_s1   <= dir_next;
			green_len_s1   <= len_next;
			ticks_left_s1  <= rem_next;
			departed_s1    <= deciding ? '0 : departed;
			for (int d = 0; d < NA; d++)
				queue_s1[d] <= q_next[d];
		end
	end

	assign result.valid       = res_valid_s1;
	assign result.phase_start = phase_start_s1;
	assign result.green_dir   = green_dir_s1;
	assign result.green_len   = green_len_s1;
	assign result.ticks_left  = ticks_left_s1;
	assign result.departed    = departed_s1;
	assign result.queue_north = aspc_pkg::QOUT_W'(queue_s1[0]);
	assign result.queue_east  = aspc_pkg::QOUT_W'(queue_s1[1]);
	assign result.queue_south = aspc_pkg::QOUT_W'(queue_s1[2]);
	assign result.queue_west  = aspc_pkg::QOUT_W'(queue_s1[3]);

	// ---------------- assertions ----------------
	a_decide_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && deciding |=> result.valid && result.phase_start)
		else $error("deciding tick did not start a phase");

	a_start_full: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.phase_start |-> result.ticks_left == result.green_len
		&& result.departed == '0)
		else $error("new phase not at full length");

	a_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !deciding |=> result.ticks_left == $past(remaining_q) - GW'(1))
		else $error("phase countdown mismatch");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !tick.ready)
		else $error("request taken while result stalled");

endmodule

`default_nettype wire

/* tb/sv/adaptive_signal_phase_controller_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the adaptive signal phase controller core.
module adaptive_signal_phase_controller_core_tb;

	localparam int QMAX        = (1 << aspc_pkg::QUEUE_BITS) - 1;
	localparam int NUM_PHASES  = 8;
	localparam int NUM_FIELDS  = 9;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [aspc_pkg::ARRIVE_W-1:0] north;
		logic [aspc_pkg::ARRIVE_W-1:0] east;
		logic [aspc_pkg::ARRIVE_W-1:0] south;
		logic [aspc_pkg::ARRIVE_W-1:0] west;
		logic [aspc_pkg::ALLOW_W-1:0]  allow;
	} tick_req_t;

	typedef struct packed {
		logic                         start;
		aspc_pkg::dir_t               dir;
		aspc_pkg::green_t             len;
		aspc_pkg::green_t             left;
		logic [aspc_pkg::ALLOW_W-1:0] departed;
		logic [aspc_pkg::QOUT_W-1:0]  qn;
		logic [aspc_pkg::QOUT_W-1:0]  qe;
		logic [aspc_pkg::QOUT_W-1:0]  qs;
		logic [aspc_pkg::QOUT_W-1:0]  qw;
	} light_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [aspc_pkg::APB_ADDR_W-1:0] paddr;
	logic [aspc_pkg::APB_DATA_W-1:0] pwdata;
	logic [aspc_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	aspc_tick_if   tick_ch();
	aspc_result_if light_ch();

	adaptive_signal_phase_controller_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.result  (light_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the controller state
	aspc_pkg::queue_t veh_queue [aspc_pkg::NUM_APPROACH];
	aspc_pkg::dir_t   cur_dir;
	aspc_pkg::green_t cur_len;
	aspc_pkg::green_t cur_left;
	aspc_pkg::green_t cfg_min;
	aspc_pkg::green_t cfg_max;

	tick_req_t     pending_ticks [$];
	light_result_t expected_lights [$];
	tick_req_t     drv_req;
	light_result_t got_light;
	light_result_t want_light;
	bit            tick_taken;

	int n_pushed;
	int n_accepted;
	int n_errors;
	int n_decides;
	int n_zero_len;
	int n_full;
	int n_cycles;
	int send_idle_pct;
	int recv_idle_pct;

	string field_names [NUM_FIELDS] = '{"phase_start", "green_dir", "green_len", "ticks_left",
		"departed", "queue_north", "queue_east", "queue_south", "queue_west"};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one tick of the intersection: arrivals, then decide or serve the green queue
	function automatic light_result_t advance_signal(input tick_req_t r);
		light_result_t                 res;
		logic [aspc_pkg::ARRIVE_W-1:0] arr [aspc_pkg::NUM_APPROACH];
		int                            sum;
		int                            best;
		int                            plan;
		int                            avail;
		int                            gone;
		res = '0;
		arr = '{r.north, r.east, r.south, r.west};
		for (int d = 0; d < aspc_pkg::NUM_APPROACH; d++) begin
			sum = int'(veh_queue[d]) + int'(arr[d]);
			veh_queue[d] = aspc_pkg::queue_t'((sum > QMAX) ? QMAX : sum);
		end
		if (cur_left == 0) begin
			// strict compare keeps the lowest index on ties
			best = 0;
			for (int d = 1; d < aspc_pkg::NUM_APPROACH; d++)
				if (veh_queue[d] > veh_queue[best])
					best = d;
			plan = int'(cfg_min) + int'(veh_queue[best]);
			if (plan < int'(cfg_min))
				plan = int'(cfg_min);
			if (plan > int'(cfg_max))
				plan = int'(cfg_max);
			cur_dir = aspc_pkg::dir_t'(best);
			cur_len = aspc_pkg::green_t'(plan);
			cur_left = cur_len;
			res.start = 1'b1;
			n_decides++;
			if (cur_len == 0)
				n_zero_len++;
		end else begin
			avail = int'(veh_queue[cur_dir]);
			gone = (avail < int'(r.allow)) ? avail : int'(r.allow);
			veh_queue[cur_dir] = aspc_pkg::queue_t'(avail - gone);
			cur_left = cur_left - aspc_pkg::green_t'(1);
			res.departed = aspc_pkg::ALLOW_W'(gone);
		end
		res.dir = cur_dir;
		res.len = cur_len;
		res.left = cur_left;
		res.qn = aspc_pkg::QOUT_W'(veh_queue[aspc_pkg::DIR_NORTH]);
		res.qe = aspc_pkg::QOUT_W'(veh_queue[aspc_pkg::DIR_EAST]);
		res.qs = aspc_pkg::QOUT_W'(veh_queue[aspc_pkg::DIR_SOUTH]);
		res.qw = aspc_pkg::QOUT_W'(veh_queue[aspc_pkg::DIR_WEST]);
		for (int d = 0; d < aspc_pkg::NUM_APPROACH; d++)
			if (veh_queue[d] == QMAX) begin
				n_full++;
				break;
			end
		return res;
	endfunction

	// four-state so that unknown result bits show up as mismatches
	function automatic logic [31:0] field_of(input light_result_t r, input int k);
		case (k)
			0: return 32'(r.start);
			1: return 32'(r.dir);
			2: return 32'(r.len);
			3: return 32'(r.left);
			4: return 32'(r.departed);
			5: return 32'(r.qn);
			6: return 32'(r.qe);
			7: return 32'(r.qs);
			default: return 32'(r.qw);
		endcase
	endfunction

	task automatic push_tick(input int n, input int e, input int s, input int w, input int a);
		tick_req_t r;
		r.north = n[aspc_pkg::ARRIVE_W-1:0];
		r.east = e[aspc_pkg::ARRIVE_W-1:0];
		r.south = s[aspc_pkg::ARRIVE_W-1:0];
		r.west = w[aspc_pkg::ARRIVE_W-1:0];
		r.allow = a[aspc_pkg::ALLOW_W-1:0];
		pending_ticks.push_back(r);
		n_pushed++;
	endtask

	// bursts of traffic at a random density, now and then a rush hour
	task automatic random_traffic(input int count);
		int remain;
		int burst;
		int density;
		int allow;
		int arr [aspc_pkg::NUM_APPROACH];
		remain = count;
		while (remain > 0) begin
			burst = $urandom_range(10, 30);
			if (burst > remain)
				burst = remain;
			density = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(0, 60);
			repeat (burst) begin
				for (int k = 0; k < aspc_pkg::NUM_APPROACH; k++)
					arr[k] = ($urandom_range(0, 99) < density) ? $urandom_range(1, 3) : 0;
				if ($urandom_range(0, 15) == 0)
					allow = $urandom_range(0, 1) ? 3 : 0;
				else
					allow = $urandom_range(1, 2);
				push_tick(arr[0], arr[1], arr[2], arr[3], allow);
			end
			remain -= burst;
		end
	endtask

	task automatic wait_drained();
		while (n_accepted != n_pushed || expected_lights.size() != 0)
			@(negedge clk);
	endtask

	task automatic apb_write(input aspc_pkg::reg_idx_t idx, input aspc_pkg::green_t val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = aspc_pkg::APB_DATA_W'(val);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_register(input aspc_pkg::reg_idx_t idx, input aspc_pkg::green_t want);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== aspc_pkg::APB_DATA_W'(want)) begin
			n_errors++;
			$display("%0t: register %s read: expected %0d, actual %0d",
				$time, idx.name(), want, prdata);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// request driver
	always @(negedge clk) begin
		if (!tick_ch.valid || tick_taken) begin
			if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				drv_req = pending_ticks.pop_front();
				tick_ch.valid <= 1'b1;
				tick_ch.arrive_north <= drv_req.north;
				tick_ch.arrive_east <= drv_req.east;
				tick_ch.arrive_south <= drv_req.south;
				tick_ch.arrive_west <= drv_req.west;
				tick_ch.depart_allow <= drv_req.allow;
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		light_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// monitor: check results, then predict for requests taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (light_ch.valid && light_ch.ready) begin
				if (expected_lights.size() == 0) begin
					n_errors++;
					$display("%0t: result with nothing expected", $time);
				end else begin
					want_light = expected_lights.pop_front();
					got_light.start = light_ch.phase_start;
					got_light.dir = aspc_pkg::dir_t'(light_ch.green_dir);
					got_light.len = light_ch.green_len;
					got_light.left = light_ch.ticks_left;
					got_light.departed = light_ch.departed;
					got_light.qn = light_ch.queue_north;
					got_light.qe = light_ch.queue_east;
					got_light.qs = light_ch.queue_south;
					got_light.qw = light_ch.queue_west;
					for (int k = 0; k < NUM_FIELDS; k++)
						if (field_of(got_light, k) !== field_of(want_light, k)) begin
							n_errors++;
							$display("%0t: %s expected %0d, actual %0d", $time,
								field_names[k], field_of(want_light, k),
								field_of(got_light, k));
						end
				end
			end
			tick_taken = tick_ch.valid && tick_ch.ready;
			if (tick_taken) begin
				drv_req.north = tick_ch.arrive_north;
				drv_req.east = tick_ch.arrive_east;
				drv_req.south = tick_ch.arrive_south;
				drv_req.west = tick_ch.arrive_west;
				drv_req.allow = tick_ch.depart_allow;
				expected_lights.push_back(advance_signal(drv_req));
				n_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d requests taken",
				n_cycles, n_accepted, n_pushed);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int new_min;
		int new_max;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.arrive_north = '0;
		tick_ch.arrive_east = '0;
		tick_ch.arrive_south = '0;
		tick_ch.arrive_west = '0;
		tick_ch.depart_allow = '0;
		light_ch.ready = 1'b0;
		tick_taken = 1'b0;
		for (int d = 0; d < aspc_pkg::NUM_APPROACH; d++)
			veh_queue[d] = '0;
		cur_dir = aspc_pkg::DIR_NORTH;
		cur_len = '0;
		cur_left = '0;
		cfg_min = aspc_pkg::MIN_GREEN_RESET;
		cfg_max = aspc_pkg::MAX_GREEN_RESET;
		send_idle_pct = 0;
		recv_idle_pct = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					new_min = int'(aspc_pkg::MIN_GREEN_RESET);
					new_max = int'(aspc_pkg::MAX_GREEN_RESET);
				end
				1: begin new_min = 0;  new_max = 63; end
				2: begin new_min = 63; new_max = 63; end
				3: begin new_min = 40; new_max = 10; end // max below min
				4: begin new_min = 1;  new_max = 1;  end
				5: begin new_min = 0;  new_max = 0;  end
				6: begin new_min = 7;  new_max = 30; end
				default: begin new_min = 20; new_max = 63; end
			endcase
			if (p != 0) begin
				apb_write(aspc_pkg::REG_MIN_GREEN, aspc_pkg::green_t'(new_min));
				apb_write(aspc_pkg::REG_MAX_GREEN, aspc_pkg::green_t'(new_max));
				cfg_min = aspc_pkg::green_t'(new_min);
				cfg_max = aspc_pkg::green_t'(new_max);
			end
			check_register(aspc_pkg::REG_MIN_GREEN, cfg_min);
			check_register(aspc_pkg::REG_MAX_GREEN, cfg_max);

			if (p < 3) begin
				send_idle_pct = 37;
				recv_idle_pct = 83;
			end else if (p < 6) begin
				send_idle_pct = 83;
				recv_idle_pct = 37;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			case (p)
				0: begin
					// first tick decides on empty queues, north wins the tie
					push_tick(0, 0, 0, 0, 0);
					push_tick(3, 3, 3, 3, 3);
					push_tick(3, 0, 0, 0, 1);
					push_tick(0, 3, 0, 0, 2);
					push_tick(0, 0, 3, 0, 3);
					push_tick(0, 0, 0, 3, 0);
					for (int i = 0; i < 14; i++)
						push_tick(i % 4, i % 4, i % 4, i % 4, (i % 3) + 1);
					random_traffic(100);
				end
				1: begin
					// empty every queue so min_green of zero gives zero-length greens
					repeat (60) push_tick(0, 0, 0, 0, 3);
					random_traffic(120);
				end
				2: begin
					// flood with no departures to hit queue saturation
					repeat (100) push_tick(3, 3, 3, 3, 0);
					random_traffic(100);
				end
				3: begin
					random_traffic(70);
					wait_drained();
					random_traffic(70);
				end
				5: begin
					repeat (40) push_tick(0, 0, 0, 0, 3);
					random_traffic(60);
				end
				default: random_traffic(p < 6 ? 140 : 150);
			endcase
			wait_drained();
			repeat (2) @(negedge clk);
		end

		repeat (5) @(negedge clk);
		$display("%0d ticks over %0d register settings: %0d phase decisions, %0d zero-length",
			n_accepted, NUM_PHASES, n_decides, n_zero_len);
		$display("greens, %0d ticks with a saturated queue, %0d errors", n_full, n_errors);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
